[rtl/cepf_pkg.sv]
// ----------------------------------------------------------------------------
// cepf_pkg
// Shared types, line codes and crc helpers for the escaped packet framer.
// ----------------------------------------------------------------------------
package cepf_pkg;

  // line control characters
  localparam logic [7:0] CH_SOH  = 8'h01;
  localparam logic [7:0] CH_EOT  = 8'h17;
  localparam logic [7:0] CH_DLE  = 8'h10;
  localparam logic [7:0] ESC_XOR = 8'h20;

  // crc-8 (reflected polynomial, start value)
  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // sequence numbers run from one up to this value, then wrap to one
  localparam logic [7:0] SEQ_FIRST = 8'h01;
  localparam logic [7:0] SEQ_MAX   = 8'hFF;

  // default depth of the command queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // one classified input beat, ready to be serialized
  typedef struct packed {
    logic       open;   // first byte of a packet: send header first
    logic [7:0] seq;    // sequence number for the header
    logic [7:0] data;   // payload byte
    logic       last;   // close the frame after this byte
    logic [7:0] crc;    // crc after this byte (sent when last)
  } cmd_t;

  // one bit-serial crc byte update, lsb first
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

  // bytes that must be escaped on the line
  function automatic logic needs_escape(logic [7:0] b);
    return (b == CH_SOH) || (b == CH_EOT) || (b == CH_DLE);
  endfunction

  // crc after the first sequence number, used at reset
  localparam logic [7:0] SEQ_CRC_FIRST = crc8_update(CRC_INIT, SEQ_FIRST);

endpackage

[rtl/cepf_front.sv]
// ----------------------------------------------------------------------------
// cepf_front
// Accepts payload beats, tracks frame state, sequence number and running crc,
// and pushes one classified command per beat into the queue.
// ----------------------------------------------------------------------------
module cepf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  // payload input
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  logic [7:0]      s_tdata_i,   // [7:0] payload_byte
  input  logic            s_tlast_i,   // is_last
  // queue push side
  output logic            push_o,
  output cepf_pkg::cmd_t  push_cmd_o,
  input  logic            full_i
);
  import cepf_pkg::*;

  logic       in_frame_q, in_frame_d;
  logic [7:0] seq_q, seq_d;          // number the next frame will carry
  logic [7:0] seq_crc_q, seq_crc_d;  // crc over that number alone
  logic [7:0] crc_q, crc_d;
  logic [7:0] crc_start;
  logic [7:0] crc_new;
  logic       accept;

  assign s_tready_o = !full_i;
  assign accept     = s_tvalid_i && !full_i;

  // crc continues the open frame or starts from the header number
  assign crc_start = in_frame_q ? crc_q : seq_crc_q;
  assign crc_new   = crc8_update(crc_start, s_tdata_i);

  // command for the back end
  always_comb begin
    push_cmd_o.open = !in_frame_q;
    push_cmd_o.seq  = seq_q;
    push_cmd_o.data = s_tdata_i;
    push_cmd_o.last = s_tlast_i;
    push_cmd_o.crc  = crc_new;
  end
  assign push_o = accept;

  // frame state update
  always_comb begin
    in_frame_d = in_frame_q;
    crc_d      = crc_q;
    seq_d      = seq_q;
    seq_crc_d  = seq_crc_q;
    if (accept) begin
      if (s_tlast_i) begin
        in_frame_d = 1'b0;
        crc_d      = CRC_INIT;
      end else begin
        in_frame_d = 1'b1;
        crc_d      = crc_new;
      end
      if (!in_frame_q) begin
        seq_d     = (seq_q == SEQ_MAX) ? SEQ_FIRST : seq_q + 8'd1;
        seq_crc_d = crc8_update(CRC_INIT, seq_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      crc_q      <= CRC_INIT;
      seq_q      <= SEQ_FIRST;
      seq_crc_q  <= SEQ_CRC_FIRST;
    end else begin
      in_frame_q <= in_frame_d;
      crc_q      <= crc_d;
      seq_q      <= seq_d;
      seq_crc_q  <= seq_crc_d;
    end
  end

endmodule

[rtl/cepf_queue.sv]
// ----------------------------------------------------------------------------
// cepf_queue
// Short register queue of commands between the front and the back end.
// ----------------------------------------------------------------------------
module cepf_queue #(
  parameter int unsigned DEPTH = cepf_pkg::QUEUE_DEPTH_DEF  // 2 .. 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cepf_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output cepf_pkg::cmd_t  head_cmd_o
);
  import cepf_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  cmd_t          mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o       = (count_q == CNT_FULL);
  assign head_valid_o = (count_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/cepf_back.sv]
// ----------------------------------------------------------------------------
// cepf_back
// Serializes queued commands into line bytes: header, escaped fields, crc
// and closing EOT, one beat per cycle into an output register unless stalled.
// ----------------------------------------------------------------------------
module cepf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  // queue head
  input  logic            head_valid_i,
  input  cepf_pkg::cmd_t  head_cmd_i,
  output logic            pop_o,
  // line output
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  output logic [7:0]      m_tdata_o,   // [7:0] line_byte
  output logic            m_tlast_o,   // burst_end
  output logic            m_tuser_o    // [0] frame_end
);
  import cepf_pkg::*;

  typedef enum logic [6:0] {
    ST_HEAD = 7'b0000001,  // start of a command
    ST_SOH1 = 7'b0000010,
    ST_SOH2 = 7'b0000100,
    ST_SEQ  = 7'b0001000,
    ST_DATA = 7'b0010000,
    ST_CRC  = 7'b0100000,
    ST_EOT  = 7'b1000000
  } phase_e;

  phase_e     phase_q, phase_d;
  phase_e     cur;
  logic       esc_q, esc_d;
  logic [7:0] raw_byte;
  logic       escapable;
  logic       adv, emit;
  logic [7:0] beat_byte;
  logic       beat_burst, beat_frame;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_burst_q, out_frame_q;

  // output register frees up when empty or taken
  assign adv  = !out_valid_q || m_tready_i;
  assign emit = adv && head_valid_i;

  // effective phase: a new command opens with the header or goes to data
  always_comb begin
    if (phase_q == ST_HEAD) begin
      cur = head_cmd_i.open ? ST_SOH1 : ST_DATA;
    end else begin
      cur = phase_q;
    end
  end

  // byte of the current phase
  always_comb begin
    case (cur)
      ST_SOH1, ST_SOH2: raw_byte = CH_SOH;
      ST_SEQ:           raw_byte = head_cmd_i.seq;
      ST_DATA:          raw_byte = head_cmd_i.data;
      ST_CRC:           raw_byte = head_cmd_i.crc;
      ST_EOT:           raw_byte = CH_EOT;
      default:          raw_byte = head_cmd_i.data;
    endcase
    escapable = (cur == ST_SEQ || cur == ST_DATA || cur == ST_CRC)
                && needs_escape(raw_byte);
  end

  // sequencer
  always_comb begin
    phase_d    = phase_q;
    esc_d      = esc_q;
    pop_o      = 1'b0;
    beat_byte  = raw_byte;
    beat_burst = 1'b0;
    beat_frame = (cur == ST_EOT);
    if (escapable && !esc_q) begin
      // first half of an escape pair
      beat_byte = CH_DLE;
      if (emit) begin
        esc_d = 1'b1;
      end
    end else begin
      if (esc_q) begin
        beat_byte = raw_byte ^ ESC_XOR;
      end
      case (cur)
        ST_SOH1: phase_d = ST_SOH2;
        ST_SOH2: phase_d = ST_SEQ;
        ST_SEQ:  phase_d = ST_DATA;
        ST_DATA: begin
          if (head_cmd_i.last) begin
            phase_d = ST_CRC;
          end else begin
            phase_d    = ST_HEAD;
            beat_burst = 1'b1;
          end
        end
        ST_CRC:  phase_d = ST_EOT;
        ST_EOT: begin
          phase_d    = ST_HEAD;
          beat_burst = 1'b1;
        end
        default: phase_d = ST_HEAD;
      endcase
      if (emit) begin
        esc_d = 1'b0;
        pop_o = beat_burst;
      end else begin
        phase_d = phase_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ST_HEAD;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      if (adv) begin
        out_valid_q <= head_valid_i;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= beat_byte;
      out_burst_q <= beat_burst;
      out_frame_q <= beat_frame;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_byte_q;
  assign m_tlast_o  = out_burst_q;
  assign m_tuser_o  = out_frame_q;

  // the closing EOT always ends the burst of its input beat
  a_eot_ends_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_frame_q |-> out_burst_q)
    else $error("closing EOT without burst end");

  // a pending escape never sits on the second SOH or the EOT phase
  a_esc_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> !(phase_q == ST_SOH2 || phase_q == ST_EOT))
    else $error("escape pending in unescaped phase");

  // retiring a command puts its burst end on the output next cycle
  a_pop_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && out_burst_q)
    else $error("command retired without burst end beat");

  // a command is only retired when it ends at the head phase
  a_pop_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> phase_q == ST_HEAD && !esc_q)
    else $error("sequencer not back at head after retire");

endmodule

[rtl/crc8_escaped_packet_framer.sv]
// ----------------------------------------------------------------------------
// crc8_escaped_packet_framer
// Byte-stuffed transmit framer with crc-8 (reflected poly 0x8C, init 0xFF) and sequence numbers.
// ----------------------------------------------------------------------------
// Each payload beat in comes out as one burst of line beats; tlast on the
// output marks the final beat of a burst and tuser marks the closing EOT. A
// packet's first byte adds SOH SOH and the sequence number, its last byte
// adds the crc and EOT, and SOH, EOT or DLE inside sequence, payload or crc
// go out as DLE plus the byte xor 0x20. The input takes a beat every cycle
// while the command queue has room; the output sequencer sends one line beat
// per cycle while the line side takes them. A beat makes 1 line byte for a
// plain mid-packet byte, 2 if escaped, up to 9 for a one-byte packet. The
// queue of QUEUE_DEPTH commands lets the input run ahead of the line side.
// ----------------------------------------------------------------------------
module crc8_escaped_packet_framer #(
  parameter int unsigned QUEUE_DEPTH = cepf_pkg::QUEUE_DEPTH_DEF  // 2 .. 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // payload input
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] payload_byte
  input  logic       s_tlast_i,   // is_last
  // line output
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [7:0] line_byte
  output logic       m_tlast_o,   // burst_end
  output logic       m_tuser_o    // [0] frame_end
);
  import cepf_pkg::*;

  logic push, full, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  // classify input beats
  cepf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  // command queue
  cepf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  // serialize onto the line
  cepf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .m_tvalid_o   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_o    (m_tdata_o),
    .m_tlast_o    (m_tlast_o),
    .m_tuser_o    (m_tuser_o)
  );

endmodule

[dv/crc8_escaped_packet_framer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc8_escaped_packet_framer_test
// Self-checking bench for the escaped packet framer. Payload beats are sent
// with random gaps and the line side stalls at random. Every accepted payload
// beat is run through a local framer model that builds the expected line
// bytes: header, byte stuffing, reflected crc-8 over 0x8C from 0xFF and the
// closing EOT. A monitor compares each line beat against the oldest expected
// one, and a watchdog ends the run if the stream stops moving.
// ----------------------------------------------------------------------------
module crc8_escaped_packet_framer_test;
  import cepf_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 24;

  // one expected beat on the line side
  typedef struct packed {
    logic [7:0] line_byte;
    logic       burst_end;
    logic       frame_end;
  } line_beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       s_tvalid_i;
  logic       s_tready_o;
  logic [7:0] s_tdata_i;   // [7:0] payload_byte
  logic       s_tlast_i;   // is_last
  logic       m_tvalid_o;
  logic       m_tready_i;
  logic [7:0] m_tdata_o;   // [7:0] line_byte
  logic       m_tlast_o;   // burst_end
  logic       m_tuser_o;   // [0] frame_end

  // framer model state
  logic       open_frame_q;
  logic [7:0] seq_q;
  logic [7:0] frame_crc_q;

  line_beat_t line_expect_q[$];
  line_beat_t burst_buf[0:8];
  int         burst_len;

  int mismatch_count;
  int payload_beats;
  int packets_closed;
  int line_beats_checked;
  int idle_cycles;
  int src_max_gap;
  int sink_max_gap;
  logic hold_line;

  crc8_escaped_packet_framer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // reflected crc-8 over poly 0x8C, one byte, lsb first
  function automatic logic [7:0] crc8_maxim_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[7:1]} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] next_seq(logic [7:0] seq);
    return (seq == SEQ_MAX) ? SEQ_FIRST : seq + 8'd1;
  endfunction

  task automatic add_plain(input logic [7:0] b, input logic eot);
    burst_buf[burst_len] = '{line_byte: b, burst_end: 1'b0, frame_end: eot};
    burst_len++;
  endtask

  // control characters go out as DLE plus the byte flipped by 0x20
  task automatic add_stuffed(input logic [7:0] b);
    if (b == CH_SOH || b == CH_EOT || b == CH_DLE) begin
      add_plain(CH_DLE, 1'b0);
      add_plain(b ^ ESC_XOR, 1'b0);
    end else begin
      add_plain(b, 1'b0);
    end
  endtask

  // build the line burst for one payload beat and queue it
  task automatic frame_payload_byte(input logic [7:0] data, input logic last);
    burst_len = 0;
    if (!open_frame_q) begin
      seq_q = next_seq(seq_q);
      add_plain(CH_SOH, 1'b0);
      add_plain(CH_SOH, 1'b0);
      add_stuffed(seq_q);
      frame_crc_q = crc8_maxim_next(CRC_INIT, seq_q);
      open_frame_q = 1'b1;
    end
    add_stuffed(data);
    frame_crc_q = crc8_maxim_next(frame_crc_q, data);
    if (last) begin
      add_stuffed(frame_crc_q);
      add_plain(CH_EOT, 1'b1);
      frame_crc_q = CRC_INIT;
      open_frame_q = 1'b0;
      packets_closed++;
    end
    burst_buf[burst_len-1].burst_end = 1'b1;
    for (int k = 0; k < burst_len; k++) line_expect_q.push_back(burst_buf[k]);
    payload_beats++;
  endtask

  task automatic check_line_beat();
    line_beat_t want;
    if (line_expect_q.size() == 0) begin
      $error("unexpected line beat: data %02h last %b user %b", m_tdata_o, m_tlast_o,
             m_tuser_o);
      mismatch_count++;
    end else begin
      want = line_expect_q.pop_front();
      line_beats_checked++;
      if (m_tdata_o !== want.line_byte) begin
        $error("line_byte: expected %02h, got %02h", want.line_byte, m_tdata_o);
        mismatch_count++;
      end
      if (m_tlast_o !== want.burst_end) begin
        $error("burst_end: expected %b, got %b", want.burst_end, m_tlast_o);
        mismatch_count++;
      end
      if (m_tuser_o !== want.frame_end) begin
        $error("frame_end: expected %b, got %b", want.frame_end, m_tuser_o);
        mismatch_count++;
      end
    end
  endtask

  // input beats first, so a same-cycle output always finds its expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_o) frame_payload_byte(s_tdata_i, s_tlast_i);
      if (m_tvalid_o && m_tready_i) check_line_beat();
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", idle_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // line side: random stalls per beat, plus a long hold on request
  initial begin
    int gap;
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_line) begin
        m_tready_i = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_line = 1'b0;
      end
      gap = $urandom_range(sink_max_gap, 0);
      if (gap > 0) begin
        m_tready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o && !hold_line);
      @(negedge clk_i);
    end
  end

  // send one payload beat; entered and left at a falling edge
  task automatic send_payload_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = $urandom_range(src_max_gap, 0);
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tdata_i  = data;
    s_tlast_i  = last;
    do @(posedge clk_i); while (!s_tready_o);
    @(negedge clk_i);
  endtask

  // random byte, biased toward the control characters
  function automatic logic [7:0] pick_payload();
    logic [7:0] r;
    r = 8'($urandom);
    case ($urandom_range(7, 0))
      0: r = CH_SOH;
      1: r = CH_EOT;
      2: r = CH_DLE;
      default: ;
    endcase
    return r;
  endfunction

  task automatic test_directed_bytes();
    logic [7:0] seq_next;
    logic [7:0] target;
    src_max_gap  = 2;
    sink_max_gap = 2;
    // one-byte packets at the extremes and on each control character
    send_payload_byte(8'h00, 1'b1);
    send_payload_byte(8'hFF, 1'b1);
    send_payload_byte(CH_SOH, 1'b1);
    send_payload_byte(CH_EOT, 1'b1);
    send_payload_byte(CH_DLE, 1'b1);
    // longer packet: escaped and look-alike bytes next to each other
    send_payload_byte(8'h21, 1'b0);
    send_payload_byte(8'h31, 1'b0);
    send_payload_byte(8'h37, 1'b0);
    send_payload_byte(8'h30, 1'b0);
    send_payload_byte(CH_DLE, 1'b0);
    send_payload_byte(CH_SOH, 1'b0);
    send_payload_byte(CH_EOT, 1'b0);
    send_payload_byte(8'h80, 1'b1);
    send_payload_byte(8'hFF, 1'b0);
    send_payload_byte(8'h00, 1'b1);
    // pick payloads whose crc lands on each control character
    for (int t = 0; t < 3; t++) begin
      target = (t == 0) ? CH_SOH : (t == 1) ? CH_EOT : CH_DLE;
      seq_next = next_seq(seq_q);
      for (int b = 0; b < 256; b++) begin
        if (crc8_maxim_next(crc8_maxim_next(CRC_INIT, seq_next), b[7:0]) == target) begin
          send_payload_byte(b[7:0], 1'b1);
          break;
        end
      end
    end
  endtask

  // line side held off while the sender keeps pushing
  task automatic test_line_backpressure();
    src_max_gap  = 0;
    sink_max_gap = 0;
    hold_line = 1'b1;
    for (int k = 0; k < 20; k++) send_payload_byte(pick_payload(), k == 19);
    while (hold_line) @(negedge clk_i);
  endtask

  task automatic test_random_packets();
    int phase_sent;
    int len;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin src_max_gap = 0; sink_max_gap = 0; end
        1: begin src_max_gap = 7; sink_max_gap = 0; end
        2: begin src_max_gap = 0; sink_max_gap = 7; end
        3: begin src_max_gap = 7; sink_max_gap = 7; end
        default: begin src_max_gap = 3; sink_max_gap = 5; end
      endcase
      phase_sent = 0;
      while (phase_sent < 20) begin
        len = ($urandom_range(7, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
        for (int k = 0; k < len; k++) send_payload_byte(pick_payload(), k == len - 1);
        phase_sent += len;
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    s_tvalid_i   = 1'b0;
    s_tdata_i    = 8'h00;
    s_tlast_i    = 1'b0;
    hold_line    = 1'b0;
    src_max_gap  = 0;
    sink_max_gap = 0;
    open_frame_q = 1'b0;
    seq_q        = 8'h00;
    frame_crc_q  = CRC_INIT;
    mismatch_count     = 0;
    payload_beats      = 0;
    packets_closed     = 0;
    line_beats_checked = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_bytes();
    test_line_backpressure();
    test_random_packets();
    s_tvalid_i = 1'b0;
    s_tlast_i  = 1'b0;

    // drain, then give the block time to show any stray beat
    while (line_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d payload beats in %0d closed packets",
             payload_beats, packets_closed);
    $display("checked %0d line beats under random gaps and a %0d-cycle line hold",
             line_beats_checked, HOLD_CYCLES);
    if (mismatch_count == 0 && line_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
